### design/rtcsm_pkg.sv
// ----------------------------------------------------------------------------
// rtcsm_pkg
// Types and constants shared by the three-wire RTC serial master.
// ----------------------------------------------------------------------------
package rtcsm_pkg;

    // Configuration register indexes
    localparam logic [7:0] CFG_HALF_PERIOD   = 8'd0;
    localparam logic [7:0] CFG_SAMPLE_OFFSET = 8'd1;

    localparam logic [15:0] HALF_PERIOD_RESET   = 16'd200;
    localparam logic [15:0] SAMPLE_OFFSET_RESET = 16'd10;

    // Bit counts of each transaction part
    localparam logic [4:0] SEND_BITS_READ  = 5'd8;
    localparam logic [4:0] SEND_BITS_WRITE = 5'd16;
    localparam logic [4:0] READ_BITS       = 5'd7;

    localparam logic [7:0] WRITE_CMD_MASK = 8'hFE;

    typedef enum logic [2:0] {
        PH_IDLE = 3'b001,
        PH_SEND = 3'b010,
        PH_READ = 3'b100
    } rtcsm_phase_t;

    // One timer tick as it arrives on the input channel
    typedef struct packed {
        logic       start_req;
        logic       mode;
        logic       format;
        logic [7:0] command_byte;
        logic [7:0] write_byte;
        logic       io_in;
    } rtcsm_in_t;

    // One result beat
    typedef struct packed {
        logic       chip_enable;
        logic       serial_clock;
        logic       io_out;
        logic       io_drive;
        logic       busy_res;
        logic       done_res;
        logic [6:0] read_raw;
        logic [6:0] read_value;
    } rtcsm_out_t;

    // Classified tick held in the queue between front and back
    typedef struct packed {
        logic        start_req;
        logic        read_mode;
        logic        hour_format;
        logic [15:0] send_word;
        logic        io_in;
    } rtcsm_tick_t;

    typedef struct packed {
        logic [15:0] half_period;
        logic [15:0] sample_offset;
    } rtcsm_cfg_t;

    // BCD decode with weights 1,2,4,8,10,20,40; hour format drops 20 and 40
    function automatic logic [6:0] rtcsm_decode(input logic [6:0] raw, input logic hour);
        logic [6:0] sum;
        sum = {3'b000, raw[3:0]};
        if (raw[4]) begin
            sum = sum + 7'd10;
        end
        if (!hour && raw[5]) begin
            sum = sum + 7'd20;
        end
        if (!hour && raw[6]) begin
            sum = sum + 7'd40;
        end
        return sum;
    endfunction

endpackage

### design/three_wire_rtc_serial_master.sv
// ----------------------------------------------------------------------------
// three_wire_rtc_serial_master
// Three-wire serial master for a real-time-clock chip, one timer tick per beat.
// ----------------------------------------------------------------------------
//
//  Channel  Ports                         Dir  Beat carries
//  -------  ----------------------------  ---  ---------------------------------
//  input    s_valid / s_ready / s_data    in   one timer tick (rtcsm_in_t)
//  result   m_valid / m_ready / m_data    out  pin levels and status (rtcsm_out_t)
//  config   cfg_valid / cfg_ready /       in   register index and 16-bit value
//           cfg_index / cfg_data
//
//  Throughput is one tick per clock cycle while the result beat is not stalled;
//  a tick waits in the tick queue, and the timing engine registers its result
//  beat on the edge that pops it.
//  The engine's state update loop sets that rate.
//  Reset (aresetn low, synchronous) empties the queue, drops the result beat and
//  returns the engine to idle with half_period 200 and sample_offset 10.
//  A stalled result holds the engine; the queue keeps taking ticks until full.
//  The config port is always ready; write it only while no tick is in flight.
//
module three_wire_rtc_serial_master
    import rtcsm_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  rtcsm_in_t  s_data,
    output logic       m_valid,
    input  logic       m_ready,
    output rtcsm_out_t m_data,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [7:0] cfg_index,
    input  logic [15:0] cfg_data
);

    rtcsm_cfg_t  cfg_reg;
    rtcsm_tick_t q_in, q_head;
    logic        q_push, q_pop, q_full, q_empty;

    // Configuration registers: accept every beat, ignore unknown indexes
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.half_period   <= HALF_PERIOD_RESET;
            cfg_reg.sample_offset <= SAMPLE_OFFSET_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_HALF_PERIOD:   cfg_reg.half_period   <= cfg_data;
                CFG_SAMPLE_OFFSET: cfg_reg.sample_offset <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Front: take ticks and build the shift word
    rtcsm_front u_front (
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_data  (q_in)
    );

    // Queue: decouple tick intake from the timing engine
    rtcsm_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_in),
        .pop       (q_pop),
        .full      (q_full),
        .empty     (q_empty),
        .head      (q_head)
    );

    // Back: advance bit timing, shift out, sample in, hold the result beat
    rtcsm_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg_reg),
        .q_empty (q_empty),
        .q_head  (q_head),
        .q_pop   (q_pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // A finished transaction shows idle pins
    a_done_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.done_res |-> !m_data.busy_res && m_data.io_drive
            && !m_data.serial_clock)
        else $error("done beat does not show idle pins");

    // The data pin is released only inside a transaction and then not driven high
    a_release_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.io_drive |-> m_data.chip_enable && !m_data.io_out)
        else $error("data pin released outside a read");

    // The queue is never popped while empty, nor pushed while full
    a_queue_guard: assert property (@(posedge aclk) disable iff (!aresetn)
        !(q_pop && q_empty) && !(q_push && q_full))
        else $error("tick queue overrun or underrun");

    // A taken tick yields a result beat on the next edge
    a_pop_result: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |=> m_valid)
        else $error("taken tick produced no result beat");

endmodule

### design/rtcsm_front.sv
// ----------------------------------------------------------------------------
// rtcsm_front
// Accepts ticks and classifies them: builds the shift word for the transfer.
// ----------------------------------------------------------------------------
module rtcsm_front
    import rtcsm_pkg::*;
(
    input  logic        s_valid,
    output logic        s_ready,
    input  rtcsm_in_t   s_data,
    input  logic        q_full,
    output logic        q_push,
    output rtcsm_tick_t q_data
);

    assign s_ready = !q_full;
    assign q_push  = s_valid && !q_full;

    // Write: command with bit 0 cleared, data byte behind it. Read: command as is.
    always_comb begin
        q_data.start_req   = s_data.start_req;
        q_data.read_mode   = s_data.mode;
        q_data.hour_format = s_data.format;
        q_data.io_in       = s_data.io_in;
        if (s_data.mode) begin
            q_data.send_word = {8'h00, s_data.command_byte};
        end else begin
            q_data.send_word = {s_data.write_byte, s_data.command_byte & WRITE_CMD_MASK};
        end
    end

endmodule

### design/rtcsm_queue.sv
// ----------------------------------------------------------------------------
// rtcsm_queue
// Short FIFO of classified ticks between front and back.
// ----------------------------------------------------------------------------
module rtcsm_queue
    import rtcsm_pkg::*;
#(
    parameter int DEPTH = 2
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        push,
    input  rtcsm_tick_t push_data,
    input  logic        pop,
    output logic        full,
    output logic        empty,
    output rtcsm_tick_t head
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST  = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULLC = CW'(DEPTH);

    rtcsm_tick_t   slot_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;

    assign full  = (count_reg == FULLC);
    assign empty = (count_reg == '0);
    assign head  = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

### design/rtcsm_back.sv
// ----------------------------------------------------------------------------
// rtcsm_back
// Bit timing engine: advances the transfer one tick per beat, holds the result.
// ----------------------------------------------------------------------------
module rtcsm_back
    import rtcsm_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  rtcsm_cfg_t  cfg,
    input  logic        q_empty,
    input  rtcsm_tick_t q_head,
    output logic        q_pop,
    output logic        m_valid,
    input  logic        m_ready,
    output rtcsm_out_t  m_data
);

    rtcsm_phase_t phase_reg, phase_next;
    logic [15:0]  tick_reg, tick_next;
    logic [4:0]   bit_reg, bit_next;
    logic [15:0]  send_reg, send_next;
    logic [6:0]   recv_reg, recv_next;
    logic         read_mode_reg, read_mode_next;
    logic         hour_reg, hour_next;
    logic         clk_reg, clk_next;
    logic         done;
    logic [4:0]   bit_inc;
    logic         half_end;
    logic         out_valid_reg;
    rtcsm_out_t   out_reg, out_next;

    // Take a tick when the result slot is free or being emptied
    assign q_pop   = !q_empty && (!out_valid_reg || m_ready);
    assign bit_inc = bit_reg + 5'd1;
    // Half period of zero behaves as one
    assign half_end = ({1'b0, tick_reg} + 17'd1) >= {1'b0, cfg.half_period};

    always_comb begin
        phase_next     = phase_reg;
        tick_next      = tick_reg;
        bit_next       = bit_reg;
        send_next      = send_reg;
        recv_next      = recv_reg;
        read_mode_next = read_mode_reg;
        hour_next      = hour_reg;
        clk_next       = clk_reg;
        done           = 1'b0;
        unique case (phase_reg)
            PH_IDLE: begin
                if (q_head.start_req) begin
                    phase_next     = PH_SEND;
                    tick_next      = '0;
                    bit_next       = '0;
                    clk_next       = 1'b0;
                    read_mode_next = q_head.read_mode;
                    send_next      = q_head.send_word;
                    if (q_head.read_mode) begin
                        recv_next = '0;
                        hour_next = q_head.hour_format;
                    end
                end
            end
            PH_SEND, PH_READ: begin
                if (half_end) begin
                    tick_next = '0;
                    if (!clk_reg) begin
                        clk_next = 1'b1;
                    end else begin
                        clk_next = 1'b0;
                        bit_next = bit_inc;
                        if (phase_reg == PH_SEND) begin
                            send_next = send_reg >> 1;
                            if (bit_inc >= (read_mode_reg ? SEND_BITS_READ : SEND_BITS_WRITE))
                            begin
                                if (read_mode_reg) begin
                                    phase_next = PH_READ;
                                    bit_next   = '0;
                                end else begin
                                    phase_next = PH_IDLE;
                                    bit_next   = '0;
                                    send_next  = '0;
                                    done       = 1'b1;
                                end
                            end
                        end else if (bit_inc >= READ_BITS) begin
                            phase_next = PH_IDLE;
                            bit_next   = '0;
                            send_next  = '0;
                            done       = 1'b1;
                        end
                    end
                end else begin
                    tick_next = tick_reg + 16'd1;
                end
                // Sample the data pin inside the low half of a read bit
                if (phase_next == PH_READ && !clk_next && tick_next == cfg.sample_offset
                    && bit_next < READ_BITS) begin
                    recv_next[bit_next[2:0]] = recv_reg[bit_next[2:0]] | q_head.io_in;
                end
            end
            default: begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    always_comb begin
        out_next.chip_enable  = (phase_next != PH_IDLE);
        out_next.busy_res     = (phase_next != PH_IDLE);
        out_next.serial_clock = clk_next;
        out_next.io_out       = (phase_next == PH_SEND) ? send_next[0] : 1'b0;
        out_next.io_drive     = (phase_next != PH_READ);
        out_next.done_res     = done;
        out_next.read_raw     = recv_next;
        out_next.read_value   = rtcsm_decode(recv_next, hour_next);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_IDLE;
            tick_reg      <= '0;
            bit_reg       <= '0;
            send_reg      <= '0;
            recv_reg      <= '0;
            read_mode_reg <= 1'b0;
            hour_reg      <= 1'b0;
            clk_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (q_pop) begin
                phase_reg     <= phase_next;
                tick_reg      <= tick_next;
                bit_reg       <= bit_next;
                send_reg      <= send_next;
                recv_reg      <= recv_next;
                read_mode_reg <= read_mode_next;
                hour_reg      <= hour_next;
                clk_reg       <= clk_next;
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            out_reg <= out_next;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the three-wire RTC serial master: every timer tick
// sent in is run through a local model of the bit timing, and each result beat
// is compared field by field with the beat the model expects.
// ----------------------------------------------------------------------------
module tb_top;
    import rtcsm_pkg::*;

    // Run control
    localparam int  CLK_HALF_NS   = 2;
    localparam int  RESET_CYCLES  = 6;
    localparam int  SETTLE_CYCLES = 8;
    localparam int  DRAIN_CYCLES  = 20;
    localparam int  CYCLE_LIMIT   = 800000;
    localparam int  MAX_REPORTS   = 10;
    localparam int  GAP_MAX       = 9;
    localparam int  RANDOM_PHASES = 6;
    localparam int  PHASE_TICKS   = 60;
    localparam int  RESET_WATCH_TICKS = 205;

    // Data pin pattern during a directed transaction
    localparam int  IO_LOW    = 0;
    localparam int  IO_HIGH   = 1;
    localparam int  IO_RANDOM = 2;

    // An index outside the register map; the block must ignore it
    localparam logic [7:0] CFG_UNUSED = 8'd2;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    rtcsm_in_t   s_data = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    rtcsm_out_t  m_data;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [7:0]  cfg_index = '0;
    logic [15:0] cfg_data = '0;

    three_wire_rtc_serial_master dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        forever #CLK_HALF_NS aclk = ~aclk;
    end

    // ------------------------------------------------------------------------
    // Local model of the serial engine: its own registers and state
    // ------------------------------------------------------------------------
    logic [15:0]  half_ticks   = HALF_PERIOD_RESET;
    logic [15:0]  sample_tick  = SAMPLE_OFFSET_RESET;
    rtcsm_phase_t rtc_phase    = PH_IDLE;
    logic [15:0]  rtc_ticks    = '0;
    logic [4:0]   rtc_bits     = '0;
    logic [15:0]  rtc_shift_out = '0;
    logic [6:0]   rtc_shift_in = '0;
    logic         rtc_rd_mode  = 1'b0;
    logic         rtc_hour     = 1'b0;
    logic         rtc_clk      = 1'b0;

    rtcsm_out_t   expected_beats[$];

    int unsigned  cycle_count    = 0;
    int unsigned  tick_count     = 0;
    int unsigned  beat_count     = 0;
    int unsigned  txn_count      = 0;
    int unsigned  read_count     = 0;
    int unsigned  mismatch_count = 0;

    // Idle pacing: each side alternates calm stretches and gappy stretches
    int           src_left = 0;
    bit           src_calm = 1'b0;
    int           snk_left = 0;
    bit           snk_calm = 1'b0;

    // Weighted BCD sum; hour format ignores the 20 and 40 weights
    function automatic logic [6:0] bcd_value(input logic [6:0] raw, input logic hour);
        int weight [7] = '{1, 2, 4, 8, 10, 20, 40};
        int sum;
        sum = 0;
        for (int k = 0; k < 7; k++) begin
            if (raw[k] && !(hour && k >= 5)) begin
                sum += weight[k];
            end
        end
        return sum[6:0];
    endfunction

    task automatic rtc_go_idle();
        rtc_phase     = PH_IDLE;
        rtc_ticks     = '0;
        rtc_bits      = '0;
        rtc_shift_out = '0;
        rtc_clk       = 1'b0;
    endtask

    // Advance the engine by one timer tick and produce the pins it shows
    task automatic advance_rtc(input rtcsm_in_t t, output rtcsm_out_t r);
        logic done;
        logic busy;
        done = 1'b0;
        if (rtc_phase == PH_IDLE) begin
            if (t.start_req) begin
                rtc_rd_mode = t.mode;
                rtc_phase   = PH_SEND;
                rtc_ticks   = '0;
                rtc_bits    = '0;
                rtc_clk     = 1'b0;
                txn_count++;
                if (t.mode) begin
                    rtc_shift_out = {8'h00, t.command_byte};
                    rtc_shift_in  = '0;
                    rtc_hour      = t.format;
                    read_count++;
                end else begin
                    // write command: force bit 0 low, data byte follows
                    rtc_shift_out = {t.write_byte, t.command_byte & WRITE_CMD_MASK};
                end
            end
        end else begin
            // a zero half period behaves as one
            if (17'(rtc_ticks) + 17'd1 >= 17'(half_ticks)) begin
                rtc_ticks = '0;
                if (!rtc_clk) begin
                    rtc_clk = 1'b1;
                end else begin
                    rtc_clk  = 1'b0;
                    rtc_bits = rtc_bits + 5'd1;
                    if (rtc_phase == PH_SEND) begin
                        rtc_shift_out = rtc_shift_out >> 1;
                        if (rtc_bits >= (rtc_rd_mode ? SEND_BITS_READ : SEND_BITS_WRITE)) begin
                            if (rtc_rd_mode) begin
                                rtc_phase = PH_READ;
                                rtc_bits  = '0;
                            end else begin
                                rtc_go_idle();
                                done = 1'b1;
                            end
                        end
                    end else if (rtc_bits >= READ_BITS) begin
                        rtc_go_idle();
                        done = 1'b1;
                    end
                end
            end else begin
                rtc_ticks = rtc_ticks + 16'd1;
            end
            // sample only in a low half and only if the offset fits inside it
            if (rtc_phase == PH_READ && !rtc_clk && rtc_ticks == sample_tick
                && rtc_bits < READ_BITS) begin
                rtc_shift_in = rtc_shift_in | (7'(t.io_in) << rtc_bits);
            end
        end

        busy           = (rtc_phase != PH_IDLE);
        r.chip_enable  = busy;
        r.serial_clock = rtc_clk;
        r.io_out       = (rtc_phase == PH_SEND) ? rtc_shift_out[0] : 1'b0;
        r.io_drive     = (rtc_phase != PH_READ);
        r.busy_res     = busy;
        r.done_res     = done;
        r.read_raw     = rtc_shift_in;
        r.read_value   = bcd_value(rtc_shift_in, rtc_hour);
    endtask

    // ------------------------------------------------------------------------
    // Pacing and item helpers
    // ------------------------------------------------------------------------
    task automatic draw_gap(inout int left, inout bit calm, output int gap);
        if (left == 0) begin
            left = $urandom_range(20, 80);
            calm = ($urandom_range(0, 2) == 0);
        end
        left--;
        gap = calm ? 0 : $urandom_range(0, GAP_MAX);
    endtask

    function automatic rtcsm_in_t random_tick(input int start_pct);
        rtcsm_in_t  t;
        logic [31:0] bits;
        bits = $urandom;
        t = bits[$bits(rtcsm_in_t)-1:0];
        t.start_req = ($urandom_range(0, 99) < start_pct);
        return t;
    endfunction

    // Drive one tick, hold it until taken, then book the beat it must cause
    task automatic send_tick(input rtcsm_in_t t);
        int         gap;
        rtcsm_out_t r;
        draw_gap(src_left, src_calm, gap);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= t;
        do @(posedge aclk); while (!s_ready);
        advance_rtc(t, r);
        expected_beats.push_back(r);
        tick_count++;
    endtask

    // Register writes go in only once every booked beat has come back
    task automatic write_reg(input logic [7:0] idx, input logic [15:0] val);
        s_valid <= 1'b0;
        while (expected_beats.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == CFG_HALF_PERIOD) begin
            half_ticks = val;
        end else if (idx == CFG_SAMPLE_OFFSET) begin
            sample_tick = val;
        end
    endtask

    // Feed plain ticks until the engine has finished its transaction
    task automatic drain_to_idle();
        while (rtc_phase != PH_IDLE) begin
            send_tick(random_tick(0));
        end
    endtask

    // One full transaction from idle back to idle
    task automatic run_txn(input logic rd, input logic fmt, input logic [7:0] cmd,
                           input logic [7:0] wb, input int io_mode, input bit keep_start);
        rtcsm_in_t t;
        t = random_tick(100);
        t.mode         = rd;
        t.format       = fmt;
        t.command_byte = cmd;
        t.write_byte   = wb;
        if (io_mode != IO_RANDOM) begin
            t.io_in = (io_mode == IO_HIGH);
        end
        send_tick(t);
        // with keep_start the request stays high while busy and on the done tick
        while (rtc_phase != PH_IDLE) begin
            t = random_tick(keep_start ? 100 : 0);
            if (io_mode != IO_RANDOM) begin
                t.io_in = (io_mode == IO_HIGH);
            end
            send_tick(t);
        end
    endtask

    // ------------------------------------------------------------------------
    // Result side: random back-pressure and the field compare
    // ------------------------------------------------------------------------
    function automatic string beat_text(input rtcsm_out_t b);
        return $sformatf("ce=%0d sclk=%0d io=%0d drv=%0d busy=%0d done=%0d raw=%02h val=%0d",
                         b.chip_enable, b.serial_clock, b.io_out, b.io_drive,
                         b.busy_res, b.done_res, b.read_raw, b.read_value);
    endfunction

    function automatic string beat_diff(input rtcsm_out_t e, input rtcsm_out_t g);
        string s;
        s = "";
        if (g.chip_enable  !== e.chip_enable)  s = {s, " chip_enable"};
        if (g.serial_clock !== e.serial_clock) s = {s, " serial_clock"};
        if (g.io_out       !== e.io_out)       s = {s, " io_out"};
        if (g.io_drive     !== e.io_drive)     s = {s, " io_drive"};
        if (g.busy_res     !== e.busy_res)     s = {s, " busy_res"};
        if (g.done_res     !== e.done_res)     s = {s, " done_res"};
        if (g.read_raw     !== e.read_raw)     s = {s, " read_raw"};
        if (g.read_value   !== e.read_value)   s = {s, " read_value"};
        return s;
    endfunction

    initial begin
        int         gap;
        rtcsm_out_t want;
        rtcsm_out_t got;
        string      diff;
        wait (aresetn === 1'b1);
        forever begin
            draw_gap(snk_left, snk_calm, gap);
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            got = m_data;
            beat_count++;
            if (expected_beats.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS) begin
                    $display("[%0t] unexpected beat %0d: %s", $realtime, beat_count,
                             beat_text(got));
                end
            end else begin
                want = expected_beats.pop_front();
                diff = beat_diff(want, got);
                if (diff != "") begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS) begin
                        $display("[%0t] beat %0d mismatch in%s", $realtime, beat_count, diff);
                        $display("    expected %s", beat_text(want));
                        $display("    actual   %s", beat_text(got));
                    end
                end
            end
        end
    end

    // Hard stop if the run hangs
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d beats still expected",
                     cycle_count, expected_beats.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Idle ticks with every field at both ends, then a read that starts on the
    // reset half period (first rising clock) and samples on the reset offset
    task automatic test_reset_values();
        rtcsm_in_t t;
        t = '1;
        t.start_req = 1'b0;
        send_tick(t);
        send_tick('0);
        t = random_tick(100);
        t.mode         = 1'b1;
        t.format       = 1'b0;
        t.command_byte = 8'h81;
        send_tick(t);
        repeat (RESET_WATCH_TICKS) send_tick(random_tick(0));
        // rush the rest of the command out, then read with a short clock
        write_reg(CFG_HALF_PERIOD, 16'd1);
        while (rtc_phase == PH_SEND) begin
            send_tick(random_tick(0));
        end
        write_reg(CFG_HALF_PERIOD, 16'd12);
        drain_to_idle();
    endtask

    // Byte extremes for both directions, full-scale decode in both formats,
    // a start held high through busy and done ticks, and a write that must
    // leave the last read data alone
    task automatic test_field_extremes();
        write_reg(CFG_HALF_PERIOD, 16'd1);
        write_reg(CFG_SAMPLE_OFFSET, 16'd0);
        run_txn(1'b0, 1'b0, 8'hFF, 8'h00, IO_RANDOM, 1'b0);
        run_txn(1'b0, 1'b1, 8'h00, 8'hFF, IO_RANDOM, 1'b0);
        run_txn(1'b1, 1'b0, 8'hFF, 8'h00, IO_HIGH, 1'b0);
        run_txn(1'b1, 1'b1, 8'h00, 8'hFF, IO_HIGH, 1'b1);
        run_txn(1'b0, 1'b0, 8'hA5, 8'h5A, IO_LOW, 1'b0);
        run_txn(1'b1, 1'b0, 8'h5A, 8'hA5, IO_LOW, 1'b0);
    endtask

    // A half period of zero runs as one tick per half
    task automatic test_zero_half_period();
        write_reg(CFG_HALF_PERIOD, 16'd0);
        run_txn(1'b1, 1'b0, 8'h8D, 8'h00, IO_RANDOM, 1'b0);
        run_txn(1'b0, 1'b0, 8'h8C, 8'h3C, IO_RANDOM, 1'b0);
    endtask

    // Sample on the last tick of a low half, then offsets that never match
    task automatic test_sample_offset_range();
        write_reg(CFG_HALF_PERIOD, 16'd3);
        write_reg(CFG_SAMPLE_OFFSET, 16'd2);
        run_txn(1'b1, 1'b0, 8'h85, 8'h00, IO_RANDOM, 1'b0);
        write_reg(CFG_SAMPLE_OFFSET, 16'd3);
        run_txn(1'b1, 1'b0, 8'h87, 8'h00, IO_HIGH, 1'b0);
        write_reg(CFG_SAMPLE_OFFSET, 16'hFFFF);
        run_txn(1'b1, 1'b1, 8'h85, 8'h00, IO_HIGH, 1'b0);
    endtask

    // Largest register values; a transaction would take millions of ticks,
    // so keep the engine idle here
    task automatic test_slowest_clock();
        write_reg(CFG_HALF_PERIOD, 16'hFFFF);
        write_reg(CFG_SAMPLE_OFFSET, 16'hFFFF);
        repeat (20) send_tick(random_tick(0));
    endtask

    // A write to an unmapped index must not disturb the timing registers
    task automatic test_unused_index();
        write_reg(CFG_HALF_PERIOD, 16'd2);
        write_reg(CFG_SAMPLE_OFFSET, 16'd1);
        write_reg(CFG_UNUSED, 16'd7);
        run_txn(1'b1, 1'b0, 8'h83, 8'h00, IO_RANDOM, 1'b0);
    endtask

    // Random ticks over several timing settings; each phase ends idle
    task automatic test_random_traffic();
        logic [15:0] hp;
        logic [15:0] so;
        int          start_pct;
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            if (p == 0) begin
                hp = 16'd1;
                so = 16'd0;
            end else begin
                hp = 16'($urandom_range(1, 6));
                so = (p == RANDOM_PHASES - 1) ? 16'hFFFF : 16'($urandom_range(0, hp));
            end
            write_reg(CFG_HALF_PERIOD, hp);
            write_reg(CFG_SAMPLE_OFFSET, so);
            start_pct = $urandom_range(5, 40);
            repeat (PHASE_TICKS) send_tick(random_tick(start_pct));
            drain_to_idle();
        end
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial begin
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_values();
        test_field_extremes();
        test_zero_half_period();
        test_sample_offset_range();
        test_slowest_clock();
        test_unused_index();
        test_random_traffic();

        // stop the source, let every booked beat come back, then settle
        s_valid <= 1'b0;
        while (expected_beats.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Sent %0d ticks, checked %0d beats in %0d cycles", tick_count, beat_count,
                 cycle_count);
        $display("Covered %0d transactions (%0d reads); %0d mismatching beats", txn_count,
                 read_count, mismatch_count);
        if (mismatch_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

### files.f
design/rtcsm_pkg.sv
design/rtcsm_front.sv
design/rtcsm_queue.sv
design/rtcsm_back.sv
design/three_wire_rtc_serial_master.sv
tb/sv/tb_top.sv
